// ===== hdl/fcw_pkg.sv =====
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

	localparam int TABLE_BYTES_DEF = 8192;
	localparam int MAX_CHAIN_DEF   = 63;

	localparam int BYTE_ADDR_W = 13;
	localparam int CLUSTER_W   = 12;
	localparam int ADDR_W      = 32;
	localparam int BASE_W      = 24;
	localparam int CBYTES_W    = 17;
	localparam int PROD_W      = CLUSTER_W + CBYTES_W;

	localparam logic [CLUSTER_W-1:0] FAT_EOC_MIN   = 12'hFF8;
	localparam logic [CLUSTER_W-1:0] FAT_BAD       = 12'hFF7;
	localparam logic [CLUSTER_W-1:0] FIRST_DATA_CL = 12'd2;

	localparam logic [BASE_W-1:0]   BASE_RESET   = 24'd16896;
	localparam logic [CBYTES_W-1:0] CBYTES_RESET = 17'd512;

	typedef enum logic [2:0] {
		STAT_DATA   = 3'd0,
		STAT_BAD    = 3'd1,
		STAT_BROKEN = 3'd2,
		STAT_TRUNC  = 3'd3,
		STAT_EMPTY  = 3'd4,
		STAT_LOADED = 3'd5
	} status_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_WALK = 1'b1
	} req_t;

	typedef enum logic {
		REG_DATA_BASE     = 1'b0,
		REG_CLUSTER_BYTES = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_ENTRY,
		S_BROKEN,
		S_TRUNC
	} walk_state_t;

	typedef struct packed {
		logic                   en;
		logic [BYTE_ADDR_W-1:0] addr;
		logic [7:0]             data;
	} tbl_wr_t;

	typedef struct packed {
		logic                 en;
		logic [CLUSTER_W-1:0] idx;
	} tbl_rd_t;

endpackage

// ===== hdl/fcw_table.sv =====
// ----------------------------------------------------------------------------
// fcw_table
// Table byte store in two banks (even and odd byte offsets), so both bytes
// of a 12-bit entry come out of one read.
// ----------------------------------------------------------------------------
module fcw_table #(
	parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF
) (
	input  logic             clk,
	input  fcw_pkg::tbl_wr_t wr,
	input  fcw_pkg::tbl_rd_t rd,
	output logic [15:0]      word
);
	import fcw_pkg::*;

	localparam int EVEN_DEPTH = (TABLE_BYTES + 1) / 2;
	localparam int ODD_DEPTH  = TABLE_BYTES / 2;
	localparam int ROW_W      = $clog2(EVEN_DEPTH);

	logic [7:0] even_mem [EVEN_DEPTH];
	logic [7:0] odd_mem  [ODD_DEPTH];

	logic [7:0]             even_rd_q;
	logic [7:0]             odd_rd_q;
	logic                   swap_q;
	logic [BYTE_ADDR_W-1:0] pos;
	logic [BYTE_ADDR_W-1:0] pos_up;
	logic [ROW_W-1:0]       wr_row;
	logic [ROW_W-1:0]       even_row;
	logic [ROW_W-1:0]       odd_row;
	logic                   wr_in_range;

	// entry byte offset is idx*3/2
	assign pos      = BYTE_ADDR_W'(rd.idx) + BYTE_ADDR_W'(rd.idx >> 1);
	assign pos_up   = pos + BYTE_ADDR_W'(pos[0]);
	assign even_row = ROW_W'(pos_up >> 1);
	assign odd_row  = ROW_W'(pos >> 1);
	assign wr_row   = ROW_W'(wr.addr >> 1);
	assign wr_in_range = ({1'b0, wr.addr} < (BYTE_ADDR_W+1)'(TABLE_BYTES));

	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range && !wr.addr[0]) begin
			even_mem[wr_row] <= wr.data;
		end
		if (wr.en && wr_in_range && wr.addr[0]) begin
			odd_mem[wr_row] <= wr.data;
		end
		if (rd.en) begin
			even_rd_q <= even_mem[even_row];
			odd_rd_q  <= odd_mem[odd_row];
			swap_q    <= pos[0];
		end
	end

	// low byte sits in the odd bank when the entry starts at an odd offset
	assign word = swap_q ? {even_rd_q, odd_rd_q} : {odd_rd_q, even_rd_q};

endmodule

// ===== hdl/fcw_addr.sv =====
// ----------------------------------------------------------------------------
// fcw_addr
// Cluster byte address: base + (cluster - 2) * bytes per cluster, with the
// product registered ahead of the add.
// ----------------------------------------------------------------------------
module fcw_addr (
	input  logic                           clk,
	input  logic                           en,
	input  logic [fcw_pkg::CLUSTER_W-1:0]  cluster,
	input  logic [fcw_pkg::BASE_W-1:0]     data_base,
	input  logic [fcw_pkg::CBYTES_W-1:0]   cluster_bytes,
	output logic [fcw_pkg::ADDR_W-1:0]     addr
);
	import fcw_pkg::*;

	logic [PROD_W-1:0]    prod_s1;
	logic [CLUSTER_W-1:0] offset;

	assign offset = cluster - FIRST_DATA_CL;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(offset) * PROD_W'(cluster_bytes);
		end
	end

	assign addr = ADDR_W'(data_base) + ADDR_W'(prod_s1);

endmodule

// ===== hdl/fat12_cluster_chain_walker_top.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top
// Load item: one result each; loads stream at one word per cycle while the result
// stream is not stalled. Walk item: per cluster a table read, then decode and emit
// from the registered bank output, held while the output register is full; a
// broken link or truncation adds a status word. Up to 64 results per walk.
// Reset idles the walker and loads the config defaults; the table keeps no reset value.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_top #(
	parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
	parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [12:0] table_byte_addr, [20:13] table_byte_value, [32:21] start_cluster
	input  logic [39:0] s_tdata,
	// [0] req_type
	input  logic        s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [11:0] cluster_index, [43:12] cluster_addr
	output logic [47:0] m_tdata,
	// [2:0] status
	output logic [2:0]  m_tuser,
	output logic        m_tlast,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);
	import fcw_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHAIN + 1);

	// configuration registers
	logic [BASE_W-1:0]   data_base_q;
	logic [CBYTES_W-1:0] cluster_bytes_q;

	// walk control
	walk_state_t          state_q, state_d;
	logic [CLUSTER_W-1:0] cur_q, cur_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;

	// output register
	logic                 out_vld_q, out_vld_d;
	logic [CLUSTER_W-1:0] out_idx_q, out_idx_d;
	logic [ADDR_W-1:0]    out_addr_q, out_addr_d;
	status_t              out_st_q, out_st_d;
	logic                 out_last_q, out_last_d;
	logic                 emit;
	logic                 out_free;

	// input fields
	req_t                   in_req;
	logic [BYTE_ADDR_W-1:0] in_byte_addr;
	logic [7:0]             in_byte_val;
	logic [CLUSTER_W-1:0]   in_start;
	logic                   in_acc;

	// table and address unit hookup
	tbl_wr_t              tbl_wr;
	tbl_rd_t              tbl_rd;
	logic [15:0]          tbl_word;
	logic [CLUSTER_W-1:0] next_cl;
	logic [ADDR_W-1:0]    cl_addr;

	assign in_req       = req_t'(s_tuser);
	assign in_byte_addr = s_tdata[12:0];
	assign in_byte_val  = s_tdata[20:13];
	assign in_start     = s_tdata[32:21];

	// the output register frees up when it is empty or being taken
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q     <= BASE_RESET;
			cluster_bytes_q <= CBYTES_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DATA_BASE:     data_base_q     <= cfg_data;
				REG_CLUSTER_BYTES: cluster_bytes_q <= cfg_data[CBYTES_W-1:0];
				default:           data_base_q     <= data_base_q;
			endcase
		end
	end

	// table writes only happen in idle and reads only during a walk, so the
	// banks never see a read and a write of the same entry at once
	assign tbl_wr.en   = in_acc && (in_req == REQ_LOAD);
	assign tbl_wr.addr = in_byte_addr;
	assign tbl_wr.data = in_byte_val;
	assign tbl_rd.en   = (state_q == S_READ);
	assign tbl_rd.idx  = cur_q;

	fcw_table #(
		.TABLE_BYTES (TABLE_BYTES)
	) u_table (
		.clk  (clk),
		.wr   (tbl_wr),
		.rd   (tbl_rd),
		.word (tbl_word)
	);

	// the product is taken in the read cycle, so it lines up with the entry
	fcw_addr u_addr (
		.clk           (clk),
		.en            (tbl_rd.en),
		.cluster       (cur_q),
		.data_base     (data_base_q),
		.cluster_bytes (cluster_bytes_q),
		.addr          (cl_addr)
	);

	// odd cluster takes the high 12 bits of the little-endian pair
	assign next_cl = cur_q[0] ? tbl_word[15:4] : tbl_word[11:0];

	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		cnt_d      = cnt_q;
		emit       = 1'b0;
		out_idx_d  = out_idx_q;
		out_addr_d = out_addr_q;
		out_st_d   = out_st_q;
		out_last_d = out_last_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					emit       = 1'b1;
					out_addr_d = '0;
					out_last_d = 1'b1;
					out_idx_d  = '0;
					if (in_req == REQ_LOAD) begin
						out_st_d = STAT_LOADED;
					end else if (in_start == '0) begin
						out_st_d = STAT_EMPTY;
					end else if (in_start < FIRST_DATA_CL || in_start >= FAT_BAD) begin
						// invalid start: report it as a broken link
						out_st_d  = STAT_BROKEN;
						out_idx_d = in_start;
					end else begin
						emit    = 1'b0;
						cur_d   = in_start;
						cnt_d   = '0;
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_ENTRY;
			end
			S_ENTRY: begin
				// hold the entry until the output register frees up
				if (out_free) begin
					emit      = 1'b1;
					out_idx_d = cur_q;
					if (next_cl == FAT_BAD) begin
						out_st_d   = STAT_BAD;
						out_addr_d = '0;
						out_last_d = 1'b1;
						state_d    = S_IDLE;
					end else begin
						out_st_d   = STAT_DATA;
						out_addr_d = cl_addr;
						out_last_d = (next_cl >= FAT_EOC_MIN);
						cnt_d      = cnt_q + 1'b1;
						if (next_cl >= FAT_EOC_MIN) begin
							state_d = S_IDLE;
						end else if (next_cl < FIRST_DATA_CL) begin
							state_d = S_BROKEN;
						end else if (cnt_q == CNT_W'(MAX_CHAIN - 1)) begin
							// report the cluster that was cut off
							cur_d   = next_cl;
							state_d = S_TRUNC;
						end else begin
							cur_d   = next_cl;
							state_d = S_READ;
						end
					end
				end
			end
			S_BROKEN, S_TRUNC: begin
				if (out_free) begin
					emit       = 1'b1;
					out_idx_d  = cur_q;
					out_addr_d = '0;
					out_last_d = 1'b1;
					out_st_d   = (state_q == S_BROKEN) ? STAT_BROKEN : STAT_TRUNC;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (emit) begin
			out_vld_d = 1'b1;
		end else if (m_tready) begin
			out_vld_d = 1'b0;
		end else begin
			out_vld_d = out_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			cnt_q     <= cnt_d;
			out_vld_q <= out_vld_d;
		end
	end

	// result payload: load only when a new word is placed
	always_ff @(posedge clk) begin
		if (emit) begin
			out_idx_q  <= out_idx_d;
			out_addr_q <= out_addr_d;
			out_st_q   <= out_st_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, out_addr_q, out_idx_q};
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

endmodule
